### hdl/atl_pkg.sv
// ----------------------------------------------------------------------------
// atl_pkg - shared types, constants and helpers of the line tokenizer
// Token kinds, error codes, scan modes, the queued beat bundle and the
// keyword tables.
// ----------------------------------------------------------------------------
package atl_pkg;

    localparam int MAX_COLUMN_DEF    = 4095;
    localparam int NUM_REGISTERS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam int          NAME_KEEP = 5;
    localparam logic [11:0] LEN_SAT   = 12'hFFF;
    localparam int          NUM_INSTR = 24;

    localparam logic [63:0] NUM_PRE_LIMIT = 64'd922337203685477580;
    localparam logic [63:0] INT_POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT_NEG_LIMIT = 64'h8000_0000_0000_0000;
    localparam logic [31:0] REG_PRE_LIMIT = 32'd214748364;
    localparam logic [31:0] REG_LIMIT     = 32'd2147483647;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_R     = 8'h52;

    typedef enum logic [3:0] {
        KIND_INSTR = 4'd0,
        KIND_REG   = 4'd1,
        KIND_LABEL = 4'd2,
        KIND_INT   = 4'd3,
        KIND_LBRK  = 4'd4,
        KIND_RBRK  = 4'd5,
        KIND_COMMA = 4'd6,
        KIND_COLON = 4'd7,
        KIND_DIR   = 4'd8,
        KIND_EOL   = 4'd9,
        KIND_ERROR = 4'd10
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_CHAR     = 3'd1,
        ERR_DIR      = 3'd2,
        ERR_INT_OVF  = 3'd3,
        ERR_REG_OVF  = 3'd4
    } t_err;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_MINUS  = 3'd1,
        MODE_NUMBER = 3'd2,
        MODE_IDENT  = 3'd3,
        MODE_DOT    = 3'd4,
        MODE_DIR    = 3'd5,
        MODE_REGRUN = 3'd6
    } t_mode;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] value;
        logic [11:0] column;
        logic [11:0] length;
        t_err        err;
    } t_tok;

    // all results of one input beat
    typedef struct packed {
        logic [1:0]   count;
        logic [15:0]  line;
        t_tok [2:0]   tok;
    } t_bundle;

    localparam logic [39:0] INSTR_NAME [NUM_INSTR] = '{
        "MOV", "ADD", "SUB", "MUL", "DIV", "AND", "OR", "XOR", "SHL", "SHR",
        "CMP", "JMP", "JE", "JNE", "JG", "JL", "JLE", "JGE", "LOAD", "STORE",
        "PUSH", "POP", "CALL", "RET"
    };
    localparam logic [2:0] INSTR_LEN [NUM_INSTR] = '{
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd2, 3'd3, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd5,
        3'd4, 3'd3, 3'd4, 3'd3
    };
    localparam logic [39:0] DIR_NAME [3] = '{"DATA", "CODE", "WORD"};

    function automatic t_tok mk_tok(t_kind kind, logic [63:0] value,
                                    logic [11:0] column, logic [11:0] length,
                                    t_err err);
        t_tok t;
        t.kind   = kind;
        t.value  = value;
        t.column = column;
        t.length = length;
        t.err    = err;
        return t;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic [7:0] to_upper(logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) ? c - 8'd32 : c;
    endfunction

    function automatic logic [39:0] name_push(logic [39:0] name, logic [11:0] tlen,
                                              logic [7:0] c);
        return (tlen < 12'(NAME_KEEP)) ? {name[31:0], c} : name;
    endfunction

    function automatic logic [11:0] len_inc(logic [11:0] tlen);
        return (tlen < LEN_SAT) ? tlen + 12'd1 : tlen;
    endfunction

    // {overflow, magnitude} after one more decimal digit
    function automatic logic [64:0] num_push(logic [63:0] mag, logic ovf, logic [3:0] d);
        logic [63:0] m;
        logic        o;
        m = mag;
        o = ovf;
        if (mag > NUM_PRE_LIMIT) begin
            o = 1'b1;
        end else begin
            m = (mag << 3) + (mag << 1) + 64'(d);
            if (m > INT_NEG_LIMIT) begin
                o = 1'b1;
            end
        end
        return {o, m};
    endfunction

    // {hit, index}
    function automatic logic [5:0] instr_find(logic [39:0] name, logic [11:0] tlen);
        logic [5:0] r;
        r = '0;
        for (int i = NUM_INSTR - 1; i >= 0; i--) begin
            if ((tlen == 12'(INSTR_LEN[i])) && (name == INSTR_NAME[i])) begin
                r = {1'b1, 5'(i)};
            end
        end
        return r;
    endfunction

endpackage

### hdl/atl_front.sv
// ----------------------------------------------------------------------------
// atl_front - character scanner
// Keeps the per-line scan state and turns each beat into a bundle of up
// to three tokens.
// ----------------------------------------------------------------------------
module atl_front #(
    parameter int MAX_COLUMN    = atl_pkg::MAX_COLUMN_DEF,
    parameter int NUM_REGISTERS = atl_pkg::NUM_REGISTERS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_char_code,
    input  logic              i_char_valid,
    input  logic              i_end_of_line,
    input  logic [15:0]       i_line_number,
    output logic              o_push,
    output atl_pkg::t_bundle  o_bundle
);

    localparam int CW = $clog2(MAX_COLUMN + 1);
    localparam logic [CW-1:0] COL_MAX = CW'(MAX_COLUMN);

    atl_pkg::t_mode r_mode, n_mode;
    logic [CW-1:0]  r_col, n_col;
    logic [CW-1:0]  r_scol, n_scol;
    logic [11:0]    r_tlen, n_tlen;
    logic [63:0]    r_mag, n_mag;
    logic           r_neg, n_neg;
    logic           r_ovf, n_ovf;
    logic [39:0]    r_name, n_name;
    logic [31:0]    r_rdig, n_rdig;
    logic           r_rovf, n_rovf;
    logic           r_rform, n_rform;
    logic           r_abort, n_abort;

    atl_pkg::t_bundle bundle;

    always_comb begin
        logic [CW-1:0]     col;
        logic [7:0]        c;
        logic [7:0]        cu;
        logic              go_start;
        logic              fin_num;
        logic              fin_id;
        logic              fin_dir;
        logic [64:0]       np;
        logic [5:0]        hit;
        logic [63:0]       lim;
        logic [1:0]        nt;
        atl_pkg::t_tok [2:0] toks;

        n_mode = r_mode;   n_col = r_col;     n_scol = r_scol;  n_tlen = r_tlen;
        n_mag = r_mag;     n_neg = r_neg;     n_ovf = r_ovf;    n_name = r_name;
        n_rdig = r_rdig;   n_rovf = r_rovf;   n_rform = r_rform; n_abort = r_abort;
        toks = '0;
        nt = '0;
        c = i_char_code;
        cu = atl_pkg::to_upper(c);
        col = r_col;
        go_start = 1'b0;
        fin_num = 1'b0;
        fin_id = 1'b0;
        fin_dir = 1'b0;

        for (int pass = 0; pass < 2; pass++) begin
            // pass 0: the character, pass 1: end of line
            fin_num = 1'b0;
            fin_id = 1'b0;
            fin_dir = 1'b0;
            go_start = 1'b0;
            if (pass == 0 && i_char_valid && !n_abort) begin
                col = n_col;
                unique case (n_mode)
                    atl_pkg::MODE_MINUS: begin
                        if (atl_pkg::is_digit(c)) begin
                            n_mode = atl_pkg::MODE_NUMBER;
                            np = atl_pkg::num_push(n_mag, n_ovf, c[3:0]);
                            {n_ovf, n_mag} = np;
                            n_tlen = atl_pkg::len_inc(n_tlen);
                        end else begin
                            toks[nt] = atl_pkg::mk_tok(atl_pkg::KIND_ERROR, '0,
                                12'(n_scol), '0, atl_pkg::ERR_CHAR);
                            nt = nt + 2'd1;
                            n_abort = 1'b1;
                            n_mode = atl_pkg::MODE_IDLE;
                        end
                    end
                    atl_pkg::MODE_NUMBER: begin
                        if (atl_pkg::is_digit(c)) begin
                            np = atl_pkg::num_push(n_mag, n_ovf, c[3:0]);
                            {n_ovf, n_mag} = np;
                            n_tlen = atl_pkg::len_inc(n_tlen);
                        end else begin
                            fin_num = 1'b1;
                            go_start = 1'b1;
                        end
                    end
                    atl_pkg::MODE_IDENT, atl_pkg::MODE_REGRUN: begin
                        if (atl_pkg::is_alpha(c) || atl_pkg::is_digit(c)
                                || c == atl_pkg::CH_UNDER) begin
                            if (n_tlen == 12'd1 && n_name == 40'(atl_pkg::CH_R)
                                    && atl_pkg::is_digit(c)) begin
                                n_rform = 1'b1;
                                n_mode = atl_pkg::MODE_REGRUN;
                                n_rdig = 32'(c[3:0]);
                            end else if (n_mode == atl_pkg::MODE_REGRUN) begin
                                if (atl_pkg::is_digit(c)) begin
                                    if (n_rdig > atl_pkg::REG_PRE_LIMIT) begin
                                        n_rovf = 1'b1;
                                    end else begin
                                        n_rdig = (n_rdig << 3) + (n_rdig << 1)
                                            + 32'(c[3:0]);
                                        if (n_rdig > atl_pkg::REG_LIMIT) begin
                                            n_rovf = 1'b1;
                                        end
                                    end
                                end else begin
                                    n_mode = atl_pkg::MODE_IDENT;
                                end
                            end
                            n_name = atl_pkg::name_push(n_name, n_tlen, cu);
                            n_tlen = atl_pkg::len_inc(n_tlen);
                        end else begin
                            fin_id = 1'b1;
                            go_start = 1'b1;
                        end
                    end
                    atl_pkg::MODE_DOT: begin
                        n_name = atl_pkg::name_push('0, '0, cu);
                        n_tlen = 12'd1;
                        n_mode = atl_pkg::MODE_DIR;
                    end
                    atl_pkg::MODE_DIR: begin
                        if (atl_pkg::is_alpha(c)) begin
                            n_name = atl_pkg::name_push(n_name, n_tlen, cu);
                            n_tlen = atl_pkg::len_inc(n_tlen);
                        end else begin
                            fin_dir = 1'b1;
                            go_start = 1'b1;
                        end
                    end
                    default: go_start = 1'b1;
                endcase
                n_col = (col < COL_MAX) ? col + 1'b1 : COL_MAX;
            end else if (pass == 1 && i_end_of_line && !n_abort) begin
                col = n_col;
                unique case (n_mode)
                    atl_pkg::MODE_MINUS: begin
                        toks[nt] = atl_pkg::mk_tok(atl_pkg::KIND_ERROR, '0,
                            12'(n_scol), '0, atl_pkg::ERR_CHAR);
                        nt = nt + 2'd1;
                        n_abort = 1'b1;
                    end
                    atl_pkg::MODE_NUMBER: fin_num = 1'b1;
                    atl_pkg::MODE_IDENT, atl_pkg::MODE_REGRUN: fin_id = 1'b1;
                    atl_pkg::MODE_DOT: begin
                        toks[nt] = atl_pkg::mk_tok(atl_pkg::KIND_ERROR, '0,
                            12'(col), '0, atl_pkg::ERR_DIR);
                        nt = nt + 2'd1;
                        n_abort = 1'b1;
                    end
                    atl_pkg::MODE_DIR: fin_dir = 1'b1;
                    default: ;
                endcase
            end

            // token completion
            if (fin_num) begin
                lim = n_neg ? atl_pkg::INT_NEG_LIMIT : atl_pkg::INT_POS_LIMIT;
                if (n_ovf || n_mag > lim) begin
                    toks[nt] = atl_pkg::mk_tok(atl_pkg::KIND_ERROR, '0, 12'(col), '0,
                        atl_pkg::ERR_INT_OVF);
                    n_abort = 1'b1;
                end else begin
                    toks[nt] = atl_pkg::mk_tok(atl_pkg::KIND_INT,
                        n_neg ? 64'd0 - n_mag : n_mag, 12'(n_scol), n_tlen,
                        atl_pkg::ERR_NONE);
                end
                nt = nt + 2'd1;
            end
            if (fin_id) begin
                hit = atl_pkg::instr_find(n_name, n_tlen);
                if (hit[5]) begin
                    toks[nt] = atl_pkg::mk_tok(atl_pkg::KIND_INSTR, 64'(hit[4:0]),
                        12'(n_scol), n_tlen, atl_pkg::ERR_NONE);
                end else if (n_rform && n_rovf) begin
                    toks[nt] = atl_pkg::mk_tok(atl_pkg::KIND_ERROR, '0, 12'(col), '0,
                        atl_pkg::ERR_REG_OVF);
                    n_abort = 1'b1;
                end else if (n_rform && n_rdig < 32'(NUM_REGISTERS)) begin
                    toks[nt] = atl_pkg::mk_tok(atl_pkg::KIND_REG, 64'(n_rdig),
                        12'(n_scol), n_tlen, atl_pkg::ERR_NONE);
                end else begin
                    toks[nt] = atl_pkg::mk_tok(atl_pkg::KIND_LABEL, '0,
                        12'(n_scol), n_tlen, atl_pkg::ERR_NONE);
                end
                nt = nt + 2'd1;
            end
            if (fin_dir) begin
                if (n_tlen == 12'd4 && n_name == atl_pkg::DIR_NAME[0]) begin
                    toks[nt] = atl_pkg::mk_tok(atl_pkg::KIND_DIR, 64'd0, 12'(n_scol),
                        12'd4, atl_pkg::ERR_NONE);
                end else if (n_tlen == 12'd4 && n_name == atl_pkg::DIR_NAME[1]) begin
                    toks[nt] = atl_pkg::mk_tok(atl_pkg::KIND_DIR, 64'd1, 12'(n_scol),
                        12'd4, atl_pkg::ERR_NONE);
                end else if (n_tlen == 12'd4 && n_name == atl_pkg::DIR_NAME[2]) begin
                    toks[nt] = atl_pkg::mk_tok(atl_pkg::KIND_DIR, 64'd2, 12'(n_scol),
                        12'd4, atl_pkg::ERR_NONE);
                end else begin
                    toks[nt] = atl_pkg::mk_tok(atl_pkg::KIND_ERROR, '0, 12'(col), '0,
                        atl_pkg::ERR_DIR);
                    n_abort = 1'b1;
                end
                nt = nt + 2'd1;
            end
            if (fin_num || fin_id || fin_dir || n_abort) begin
                n_mode = atl_pkg::MODE_IDLE;
            end

            // first character of a new token
            if (go_start && !n_abort) begin
                unique case (c)
                    atl_pkg::CH_SPACE, atl_pkg::CH_TAB: ;
                    atl_pkg::CH_LBRK: begin
                        toks[nt] = atl_pkg::mk_tok(atl_pkg::KIND_LBRK, '0, 12'(col),
                            12'd1, atl_pkg::ERR_NONE);
                        nt = nt + 2'd1;
                    end
                    atl_pkg::CH_RBRK: begin
                        toks[nt] = atl_pkg::mk_tok(atl_pkg::KIND_RBRK, '0, 12'(col),
                            12'd1, atl_pkg::ERR_NONE);
                        nt = nt + 2'd1;
                    end
                    atl_pkg::CH_COMMA: begin
                        toks[nt] = atl_pkg::mk_tok(atl_pkg::KIND_COMMA, '0, 12'(col),
                            12'd1, atl_pkg::ERR_NONE);
                        nt = nt + 2'd1;
                    end
                    atl_pkg::CH_COLON: begin
                        toks[nt] = atl_pkg::mk_tok(atl_pkg::KIND_COLON, '0, 12'(col),
                            12'd1, atl_pkg::ERR_NONE);
                        nt = nt + 2'd1;
                    end
                    default: begin
                        if (atl_pkg::is_digit(c) || c == atl_pkg::CH_MINUS) begin
                            n_mode = atl_pkg::is_digit(c) ? atl_pkg::MODE_NUMBER
                                                          : atl_pkg::MODE_MINUS;
                            n_scol = col;
                            n_tlen = 12'd1;
                            n_mag = atl_pkg::is_digit(c) ? 64'(c[3:0]) : 64'd0;
                            n_neg = (c == atl_pkg::CH_MINUS);
                            n_ovf = 1'b0;
                        end else if (atl_pkg::is_alpha(c) || c == atl_pkg::CH_UNDER) begin
                            n_mode = atl_pkg::MODE_IDENT;
                            n_scol = col;
                            n_tlen = 12'd1;
                            n_name = 40'(cu);
                            n_rform = 1'b0;
                            n_rdig = '0;
                            n_rovf = 1'b0;
                        end else if (c == atl_pkg::CH_DOT) begin
                            n_mode = atl_pkg::MODE_DOT;
                            n_scol = (col < COL_MAX) ? col + 1'b1 : COL_MAX;
                        end else begin
                            toks[nt] = atl_pkg::mk_tok(atl_pkg::KIND_ERROR, '0,
                                12'(col), '0, atl_pkg::ERR_CHAR);
                            nt = nt + 2'd1;
                            n_abort = 1'b1;
                            n_mode = atl_pkg::MODE_IDLE;
                        end
                    end
                endcase
            end

            if (pass == 1 && i_end_of_line) begin
                if (!n_abort) begin
                    toks[nt] = atl_pkg::mk_tok(atl_pkg::KIND_EOL, '0, 12'(col), '0,
                        atl_pkg::ERR_NONE);
                    nt = nt + 2'd1;
                end
                n_mode = atl_pkg::MODE_IDLE;  n_col = CW'(1);   n_scol = '0;
                n_tlen = '0;  n_mag = '0;  n_neg = 1'b0;  n_ovf = 1'b0;
                n_name = '0;  n_rdig = '0; n_rovf = 1'b0; n_rform = 1'b0;
                n_abort = 1'b0;
            end
        end

        bundle.count = nt;
        bundle.line  = i_line_number;
        bundle.tok   = toks;
    end

    assign o_push   = i_take && (bundle.count != 2'd0);
    assign o_bundle = bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= atl_pkg::MODE_IDLE;  r_col <= CW'(1);  r_scol <= '0;
            r_tlen <= '0;  r_mag <= '0;  r_neg <= 1'b0;  r_ovf <= 1'b0;
            r_name <= '0;  r_rdig <= '0; r_rovf <= 1'b0; r_rform <= 1'b0;
            r_abort <= 1'b0;
        end else if (i_take) begin
            r_mode <= n_mode;  r_col <= n_col;  r_scol <= n_scol;
            r_tlen <= n_tlen;  r_mag <= n_mag;  r_neg <= n_neg;  r_ovf <= n_ovf;
            r_name <= n_name;  r_rdig <= n_rdig; r_rovf <= n_rovf;
            r_rform <= n_rform; r_abort <= n_abort;
        end
    end

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col != '0) && (r_col <= COL_MAX))
        else $error("column counter out of range");

    a_abort_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_abort |-> (r_mode == atl_pkg::MODE_IDLE))
        else $error("aborted line still scanning");

    a_eol_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_end_of_line) |=> (!r_abort && r_col == CW'(1)))
        else $error("end of line did not reset the line");

endmodule

### hdl/atl_queue.sv
// ----------------------------------------------------------------------------
// atl_queue - bundle queue between scanner and token sender
// Small flip-flop FIFO; lets the scanner run while tokens wait.
// ----------------------------------------------------------------------------
module atl_queue #(
    parameter int DEPTH = atl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  atl_pkg::t_bundle  i_bundle,
    input  logic              i_pop,
    output atl_pkg::t_bundle  o_head,
    output logic              o_empty,
    output logic              o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    atl_pkg::t_bundle r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [NW-1:0] r_cnt, n_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = i_push ? ((r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1) : r_wr;
        n_rd  = i_pop  ? ((r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1) : r_rd;
        n_cnt = r_cnt + NW'(i_push) - NW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("push into full queue");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NW'(DEPTH))
        else $error("queue count above depth");

endmodule

### hdl/atl_back.sv
// ----------------------------------------------------------------------------
// atl_back - token sender
// Walks the tokens of the head bundle, one per output beat.
// ----------------------------------------------------------------------------
module atl_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  atl_pkg::t_bundle  i_head,
    input  logic              i_empty,
    input  logic              i_stall,
    output logic              o_pop,
    output logic              o_valid,
    output atl_pkg::t_tok     o_tok,
    output logic [15:0]       o_line,
    output logic              o_last
);

    logic [1:0] r_idx, n_idx;
    logic       take;

    assign o_valid = !i_empty;
    assign o_tok   = i_head.tok[r_idx];
    assign o_line  = i_head.line;
    assign o_last  = (r_idx == i_head.count - 2'd1);
    assign take    = o_valid && !i_stall;
    assign o_pop   = take && o_last;

    always_comb begin
        n_idx = r_idx;
        if (take) begin
            n_idx = o_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

    a_idx_in_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_idx < i_head.count))
        else $error("token index beyond bundle");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(r_idx))
        else $error("token index moved while stalled");

endmodule

### hdl/assembler_line_tokenizer.sv
// ----------------------------------------------------------------------------
// assembler_line_tokenizer - source line to token stream
// Scans assembler source one character per beat and sends tokens with
// column, length and line number.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_valid / o_stall): one character per beat, with
//    i_char_valid low for a line that holds no character and
//    i_end_of_line high on the last beat of each line.
//  - Output channel (o_valid / i_stall): one token per beat; o_last_of_run
//    marks the last token caused by one input beat (a beat causes 0 to 3).
//  - A completed token is written into the bundle queue and sent from its head.
//  - Throughput: one input beat per cycle while i_stall is low and every
//    beat yields at most one token; the sender moves one token per cycle
//    while i_stall is low, and the bundle queue absorbs multi-token beats.
//  - o_stall rises only when the bundle queue is full; i_stall holds the
//    current token and lets the scanner keep filling the queue.
//  - Reset (synchronous, active low) empties the queue and starts a new
//    line at column 1.
//  - After an error token the rest of the line is dropped; no end-of-line
//    token follows, and the end-of-line beat starts the next line.
// ----------------------------------------------------------------------------
module assembler_line_tokenizer #(
    parameter int MAX_COLUMN    = atl_pkg::MAX_COLUMN_DEF,
    parameter int NUM_REGISTERS = atl_pkg::NUM_REGISTERS_DEF,
    parameter int QUEUE_DEPTH   = atl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // character beats
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_char_code,
    input  logic               i_char_valid,
    input  logic               i_end_of_line,
    input  logic [15:0]        i_line_number,
    // token beats
    output logic               o_valid,
    input  logic               i_stall,
    output logic [3:0]         o_token_kind,
    output logic signed [63:0] o_token_value,
    output logic [11:0]        o_column,
    output logic [11:0]        o_length,
    output logic [15:0]        o_token_line,
    output logic [2:0]         o_error_code,
    output logic               o_last_of_run
);

    atl_pkg::t_bundle front_bundle;
    atl_pkg::t_bundle head;
    atl_pkg::t_tok    tok;
    logic             take;
    logic             push;
    logic             pop;
    logic             q_empty;
    logic             q_full;

    // a beat enters whenever the queue has room
    assign o_stall = q_full;
    assign take    = i_valid && !q_full;

    atl_front #(
        .MAX_COLUMN    (MAX_COLUMN),
        .NUM_REGISTERS (NUM_REGISTERS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_char_code   (i_char_code),
        .i_char_valid  (i_char_valid),
        .i_end_of_line (i_end_of_line),
        .i_line_number (i_line_number),
        .o_push        (push),
        .o_bundle      (front_bundle)
    );

    atl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (front_bundle),
        .i_pop    (pop),
        .o_head   (head),
        .o_empty  (q_empty),
        .o_full   (q_full)
    );

    atl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (q_empty),
        .i_stall (i_stall),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_tok   (tok),
        .o_line  (o_token_line),
        .o_last  (o_last_of_run)
    );

    assign o_token_kind  = tok.kind;
    assign o_token_value = tok.value;
    assign o_column      = tok.column;
    assign o_length      = tok.length;
    assign o_error_code  = tok.err;

    // a beat taken with room in the queue is never dropped
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("bundle pushed into full queue");

endmodule
